/* rtl/core/srtf_pkg.sv */
// Shared types and constants for the shortest-remaining-time scheduler.
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

   // Width of every tick, id and length field.
   localparam int unsigned FIELD_W = 8;

   // Item kind codes.
   localparam logic KIND_ARRIVE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // Reset value of the time limit register.
   localparam logic [FIELD_W-1:0] TIME_LIMIT_RESET = 8'd100;

   // One job table entry as held in the entry memory.
   typedef struct packed {
      logic [FIELD_W-1:0] job;
      logic [FIELD_W-1:0] remaining;
      logic [FIELD_W-1:0] burst;
      logic [FIELD_W-1:0] arrival;
      logic [FIELD_W-1:0] start_tick;
      logic [FIELD_W-1:0] order;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the accepted item
      logic do_stop;    // answer with stopped
      logic do_arrive;  // store the arriving job and answer
      logic scan_init;  // clear the scan counter and the best candidate
      logic rd_issue;   // read the entry at the scan counter and advance it
      logic do_tick;    // run the chosen job for one quantum and answer
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic stopped;     // current tick has reached the limit
      logic is_tick;     // captured item is a tick
      logic last_issue;  // scan counter points at the last slot
   } stat_type;

endpackage : srtf_pkg

`default_nettype wire

/* rtl/core/srtf_tick_scheduler.sv */
// Top level of the shortest-remaining-time-first tick scheduler.
//
//   Channel   Ports                               Transfer when
//   request   start, busy, req_*                  start high and busy low
//   response  rsp_strobe, rsp_*                   rsp_strobe high (one cycle)
//   config    csr_valid, csr_ready, csr_data      csr_valid and csr_ready high
//
// An arrive item, or any item once the clock has reached the time limit,
// is answered from the execute state, with its result registered there. A
// tick item keeps the block busy through the execute, scan, drain and
// update states and is answered from the update state: the job table sits
// in a single-port read memory and the minimum search reads one entry per cycle.
// Reset is synchronous and clears the job table's valid bits at once, so no
// clearing pass is needed. Results cannot be stalled; a new item may be
// transferred in the cycle its predecessor's result is shown.
`timescale 1ns / 1ps
`default_nettype none

module srtf_tick_scheduler
   import srtf_pkg::*;
#(
   parameter int unsigned SLOTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_kind,
   input  wire logic [FIELD_W-1:0] req_job_id,
   input  wire logic [FIELD_W-1:0] req_burst_length,
   output logic                    rsp_strobe,
   output logic                    rsp_accepted,
   output logic                    rsp_idle,
   output logic      [FIELD_W-1:0] rsp_ran_id,
   output logic                    rsp_finished,
   output logic      [FIELD_W-1:0] rsp_turnaround,
   output logic      [FIELD_W-1:0] rsp_waiting,
   output logic      [FIELD_W-1:0] rsp_response,
   output logic                    rsp_stopped,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [FIELD_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // The user must write the register only while the block is idle; the block itself does not enforce this.
   assign csr_ready = 1'b1;

   srtf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   srtf_dpath #(
      .SLOTS(SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_job_id       (req_job_id),
      .req_burst_length (req_burst_length),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_accepted     (rsp_accepted),
      .rsp_idle         (rsp_idle),
      .rsp_ran_id       (rsp_ran_id),
      .rsp_finished     (rsp_finished),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting),
      .rsp_response     (rsp_response),
      .rsp_stopped      (rsp_stopped)
   );

`ifndef SYNTHESIS
   // A transferred item always makes the block busy in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item transfer did not raise busy");

   // A result is shown only after the controller has returned to idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // A finishing job comes only from a tick that ran.
   a_finish_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_finished |-> !rsp_idle && !rsp_stopped && !rsp_accepted)
      else $error("finished flag on a result that did not run a job");

   // A stopped result carries no run information.
   a_stop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_stopped |-> rsp_ran_id == '0 && !rsp_accepted && !rsp_idle)
      else $error("stopped result carries other fields");
`endif

endmodule : srtf_tick_scheduler

`default_nettype wire

/* rtl/core/srtf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module srtf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : srtf_ram

`default_nettype wire

/* rtl/core/srtf_ctrl.sv */
// Controller state machine that sequences stop, arrive, scan and tick update.
`timescale 1ns / 1ps
`default_nettype none

module srtf_ctrl
   import srtf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output logic          busy,
   output cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.stopped) begin
               cmd.do_stop = 1'b1;
               state_in    = ST_IDLE;
            end else if (!stat.is_tick) begin
               cmd.do_arrive = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_issue = 1'b1;
            if (stat.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last read entry is compared in this cycle.
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.do_tick = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule : srtf_ctrl

`default_nettype wire

/* rtl/core/srtf_dpath.sv */
// Datapath: job table, minimum search, clock and result registers.
`timescale 1ns / 1ps
`default_nettype none

module srtf_dpath
   import srtf_pkg::*;
#(
   parameter int unsigned SLOTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   input  wire logic               req_kind,
   input  wire logic [FIELD_W-1:0] req_job_id,
   input  wire logic [FIELD_W-1:0] req_burst_length,
   input  wire logic               csr_valid,
   input  wire logic [FIELD_W-1:0] csr_data,
   output logic                    rsp_strobe,
   output logic                    rsp_accepted,
   output logic                    rsp_idle,
   output logic      [FIELD_W-1:0] rsp_ran_id,
   output logic                    rsp_finished,
   output logic      [FIELD_W-1:0] rsp_turnaround,
   output logic      [FIELD_W-1:0] rsp_waiting,
   output logic      [FIELD_W-1:0] rsp_response,
   output logic                    rsp_stopped
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Configuration and global state.
   logic [FIELD_W-1:0] time_limit_ff;
   logic [FIELD_W-1:0] now_ff;
   logic [FIELD_W-1:0] order_cnt_ff;

   // Per-slot flags kept in flip-flops.
   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] started_ff;

   // Captured item.
   logic               item_kind_ff;
   logic [FIELD_W-1:0] item_job_ff;
   logic [FIELD_W-1:0] item_burst_ff;

   // Scan control.
   logic [IDX_W-1:0] scan_cnt_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_pend_ff;

   // Best candidate so far.
   logic               best_found_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [FIELD_W-1:0] best_age_ff;
   logic               best_started_ff;
   entry_type          best_ff;

   // Result registers.
   logic               strobe_ff;
   logic               accepted_ff;
   logic               idle_ff;
   logic [FIELD_W-1:0] ran_id_ff;
   logic               finished_ff;
   logic [FIELD_W-1:0] turnaround_ff;
   logic [FIELD_W-1:0] waiting_ff;
   logic [FIELD_W-1:0] response_ff;
   logic               stopped_ff;

   // Entry memory ports.
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   entry_type        ram_rd_data;

   // Combinational helpers.
   logic               free_found;
   logic [IDX_W-1:0]   free_idx;
   logic               arrive_ok;
   logic               cand;
   logic [FIELD_W-1:0] cand_age;
   logic               take;
   logic [FIELD_W-1:0] run_start;
   logic [FIELD_W-1:0] run_rem;
   logic [FIELD_W-1:0] now_next;
   logic [FIELD_W-1:0] run_tat;
   entry_type          arrive_entry;
   entry_type          run_entry;

   srtf_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (scan_cnt_ff),
      .rd_data (ram_rd_data)
   );

   // Lowest-numbered free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign arrive_ok = free_found && (item_burst_ff != '0);

   // Compare the entry read in the previous cycle against the best one.
   assign cand     = cmp_pend_ff && valid_ff[cmp_idx_ff] && (ram_rd_data.remaining != '0);
   assign cand_age = order_cnt_ff - ram_rd_data.order;
   assign take     = cand && (!best_found_ff
                     || (ram_rd_data.remaining < best_ff.remaining)
                     || ((ram_rd_data.remaining == best_ff.remaining)
                         && (cand_age > best_age_ff)));

   // One quantum of the chosen job.
   assign run_start = best_started_ff ? best_ff.start_tick : now_ff;
   assign run_rem   = best_ff.remaining - 8'd1;
   assign now_next  = now_ff + 8'd1;
   assign run_tat   = now_next - best_ff.arrival;

   always_comb begin
      arrive_entry            = '0;
      arrive_entry.job        = item_job_ff;
      arrive_entry.remaining  = item_burst_ff;
      arrive_entry.burst      = item_burst_ff;
      arrive_entry.arrival    = now_ff;
      arrive_entry.order      = order_cnt_ff;
      run_entry               = best_ff;
      run_entry.remaining     = run_rem;
      run_entry.start_tick    = run_start;
   end

   // Memory write port, shared by arrival and tick update.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = free_idx;
      ram_wr_data = arrive_entry;
      if (cmd.do_arrive && arrive_ok) begin
         ram_wr_en = 1'b1;
      end else if (cmd.do_tick && best_found_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = best_idx_ff;
         ram_wr_data = run_entry;
      end
   end

   // Time limit register; the write channel is always ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_limit_ff <= TIME_LIMIT_RESET;
      end else if (csr_valid) begin
         time_limit_ff <= csr_data;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_kind_ff  <= req_kind;
         item_job_ff   <= req_job_id;
         item_burst_ff <= req_burst_length;
      end
   end

   // Clock, insertion counter and slot flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         order_cnt_ff <= '0;
         valid_ff     <= '0;
         started_ff   <= '0;
      end else if (cmd.do_arrive && arrive_ok) begin
         order_cnt_ff         <= order_cnt_ff + 8'd1;
         valid_ff[free_idx]   <= 1'b1;
         started_ff[free_idx] <= 1'b0;
      end else if (cmd.do_tick) begin
         now_ff <= now_next;
         if (best_found_ff) begin
            if (run_rem == '0) begin
               valid_ff[best_idx_ff]   <= 1'b0;
               started_ff[best_idx_ff] <= 1'b0;
            end else begin
               started_ff[best_idx_ff] <= 1'b1;
            end
         end
      end
   end

   // Scan counter and compare pipeline flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         cmp_pend_ff <= 1'b0;
      end else begin
         cmp_pend_ff <= cmd.rd_issue;
         if (cmd.scan_init) begin
            scan_cnt_ff <= '0;
         end else if (cmd.rd_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
      end
      cmp_idx_ff <= scan_cnt_ff;
   end

   // Best candidate registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         best_found_ff <= 1'b0;
      end else if (take) begin
         best_found_ff <= 1'b1;
      end
      if (take) begin
         best_idx_ff     <= cmp_idx_ff;
         best_age_ff     <= cand_age;
         best_started_ff <= started_ff[cmp_idx_ff];
         best_ff         <= ram_rd_data;
      end
   end

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.do_stop || cmd.do_arrive || cmd.do_tick;
      end
   end

   // Result payload; fields that mean nothing for an item are zero.
   always_ff @(posedge clock) begin
      if (cmd.do_stop || cmd.do_arrive || cmd.do_tick) begin
         accepted_ff   <= cmd.do_arrive && arrive_ok;
         stopped_ff    <= cmd.do_stop;
         idle_ff       <= cmd.do_tick && !best_found_ff;
         ran_id_ff     <= '0;
         finished_ff   <= 1'b0;
         turnaround_ff <= '0;
         waiting_ff    <= '0;
         response_ff   <= '0;
         if (cmd.do_tick && best_found_ff) begin
            ran_id_ff <= best_ff.job;
            if (run_rem == '0) begin
               finished_ff   <= 1'b1;
               turnaround_ff <= run_tat;
               waiting_ff    <= run_tat - best_ff.burst;
               response_ff   <= run_start - best_ff.arrival;
            end
         end
      end
   end

   assign stat.stopped    = (now_ff >= time_limit_ff);
   assign stat.is_tick    = (item_kind_ff == KIND_TICK);
   assign stat.last_issue = (scan_cnt_ff == LAST_IDX);

   assign rsp_strobe     = strobe_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_idle       = idle_ff;
   assign rsp_ran_id     = ran_id_ff;
   assign rsp_finished   = finished_ff;
   assign rsp_turnaround = turnaround_ff;
   assign rsp_waiting    = waiting_ff;
   assign rsp_response   = response_ff;
   assign rsp_stopped    = stopped_ff;

endmodule : srtf_dpath

`default_nettype wire
